>>> design/bounded_deque_with_listing_macros.svh
// assertion macros for the bounded deque with listing
// used by bounded_deque_with_listing.sv, expects clk and arst_n in scope
`ifndef BOUNDED_DEQUE_WITH_LISTING_MACROS_SVH
`define BOUNDED_DEQUE_WITH_LISTING_MACROS_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define BDQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDQ_ASSERT_ALWAYS(lbl, cond, msg)
`define BDQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/bdq_pkg.sv
// types, codes and ring arithmetic for the bounded deque with listing
// no dependencies
`default_nettype none

package bdq_pkg;

	localparam int DEPTH = 64;
	localparam int DATA_W = 32;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_POP_FRONT  = 3'd1,
		FN_LIST       = 3'd2,
		FN_PUSH_BACK  = 3'd3,
		FN_POP_BACK   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		func_t                    func;
		logic signed [DATA_W-1:0] value_in;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		status_t                  status;
		logic                     last;
	} res_t;

	// ring position a + b modulo DEPTH, valid for a < DEPTH and b <= DEPTH
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/bounded_deque_with_listing.sv
// bounded double-ended queue with listing, ring store in one synchronous ram
// depends on bdq_pkg and bounded_deque_with_listing_macros.svh
//
//   channel | valid     | stall     | payload | direction
//   --------+-----------+-----------+---------+----------
//   command | cmd_valid | cmd_stall | cmd     | in
//   result  | res_valid | res_stall | res     | out
//
// push and pop: accept then execute on the read data
// list: one ram read per listed entry
// reset empties the queue at once; ram contents are left as they are
// a stalled result holds in the output register and the sequencer waits on it
`default_nettype none

`include "bounded_deque_with_listing_macros.svh"

module bounded_deque_with_listing
	import bdq_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic cmd_valid,
	output logic       cmd_stall,
	input  wire  cmd_t cmd,
	output logic       res_valid,
	input  wire  logic res_stall,
	output res_t       res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LIST
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	res_t                     res_q;
	logic                     res_valid_q;
	logic [PTR_W-1:0]         front_q;
	logic [CNT_W-1:0]         count_q;
	logic [PTR_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] rd_data_q;

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic             out_free;
	logic             res_load;
	logic             is_full;
	logic             is_empty;
	logic             list_done;
	logic [PTR_W-1:0] front_dec;
	logic [PTR_W-1:0] front_inc;
	logic [PTR_W-1:0] back_pos;
	logic [PTR_W-1:0] last_pos;
	logic [PTR_W-1:0] list_next;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		out_free  = !res_valid_q || !res_stall;
		is_full   = (count_q == CNT_W'(DEPTH));
		is_empty  = (count_q == '0);
		list_done = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
		front_dec = ring_add(front_q, CNT_W'(DEPTH - 1));
		front_inc = ring_add(front_q, CNT_W'(1));
		back_pos  = ring_add(front_q, count_q);
		last_pos  = ring_add(front_q, count_q - CNT_W'(1));
		list_next = ring_add(front_q, CNT_W'(idx_q) + CNT_W'(1));

		// a new result enters the output register this cycle
		res_load = out_free && ((state_q == S_LIST) || ((state_q == S_EXEC)
			&& (cmd_q.func == FN_PUSH_FRONT || cmd_q.func == FN_PUSH_BACK
			|| cmd_q.func == FN_POP_FRONT || cmd_q.func == FN_POP_BACK
			|| (cmd_q.func == FN_LIST && is_empty))));

		rd_en   = 1'b0;
		rd_addr = front_q;
		if (state_q == S_IDLE && cmd_valid) begin
			rd_en   = 1'b1;
			rd_addr = (cmd.func == FN_POP_BACK) ? last_pos : front_q;
		end else if (state_q == S_LIST && out_free && !list_done) begin
			rd_en   = 1'b1;
			rd_addr = list_next;
		end

		wr_en   = (state_q == S_EXEC) && out_free && !is_full
			&& (cmd_q.func == FN_PUSH_FRONT || cmd_q.func == FN_PUSH_BACK);
		wr_addr = (cmd_q.func == FN_PUSH_FRONT) ? front_dec : back_pos;
	end

	// entry store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd_q.value_in;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall && !res_load) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q.func)
						FN_PUSH_FRONT, FN_PUSH_BACK: begin
							if (out_free) begin
								res_valid_q     <= 1'b1;
								res_q.value_out <= '0;
								res_q.last      <= 1'b1;
								if (is_full) begin
									res_q.status <= ST_FULL;
								end else begin
									res_q.status <= ST_OK;
									count_q      <= count_q + CNT_W'(1);
									if (cmd_q.func == FN_PUSH_FRONT) begin
										front_q <= front_dec;
									end
								end
								state_q <= S_IDLE;
							end
						end
						FN_POP_FRONT, FN_POP_BACK: begin
							if (out_free) begin
								res_valid_q <= 1'b1;
								res_q.last  <= 1'b1;
								if (is_empty) begin
									res_q.value_out <= '0;
									res_q.status    <= ST_EMPTY;
								end else begin
									res_q.value_out <= rd_data_q;
									res_q.status    <= ST_OK;
									count_q         <= count_q - CNT_W'(1);
									if (cmd_q.func == FN_POP_FRONT) begin
										front_q <= front_inc;
									end
								end
								state_q <= S_IDLE;
							end
						end
						FN_LIST: begin
							if (is_empty) begin
								if (out_free) begin
									res_valid_q     <= 1'b1;
									res_q.value_out <= '0;
									res_q.status    <= ST_EMPTY;
									res_q.last      <= 1'b1;
									state_q         <= S_IDLE;
								end
							end else begin
								idx_q   <= '0;
								state_q <= S_LIST;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_LIST: begin
					if (out_free) begin
						res_valid_q     <= 1'b1;
						res_q.value_out <= rd_data_q;
						res_q.status    <= ST_OK;
						res_q.last      <= list_done;
						if (list_done) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + PTR_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BDQ_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`BDQ_ASSERT_ALWAYS(a_front_range, CNT_W'(front_q) < CNT_W'(DEPTH), "front beyond ring")
	`BDQ_ASSERT_IMPLY(a_err_zero, res_valid_q && res_q.status != ST_OK, res_q.value_out == '0 && res_q.last, "error result not zero or not last")
	`BDQ_ASSERT_NEXT(a_accept_exec, cmd_valid && !cmd_stall, state_q == S_EXEC, "accepted transaction not executed")
	`BDQ_ASSERT_IMPLY(a_list_index, state_q == S_LIST, CNT_W'(idx_q) < count_q, "listing index past count")
	`BDQ_ASSERT_IMPLY(a_write_room, wr_en, count_q < CNT_W'(DEPTH), "write into a full ring")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for bounded_deque_with_listing: directed and random deque traffic
// depends on bdq_pkg and the design sources; a scoreboard class mirrors the ring and its count
module testbench;
	import bdq_pkg::*;

	localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FN_SPARE_LAST = 3'd7;
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;
	localparam int LONG_HOLD = 200;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

	class deque_shadow;
		logic signed [DATA_W-1:0] slots [DEPTH];
		int unsigned head;
		int unsigned occupied;
		res_t expected_results[$];
		int unsigned mismatches;

		function new();
			head = 0;
			occupied = 0;
			mismatches = 0;
		endfunction

		function void add_result(logic signed [DATA_W-1:0] v, status_t s, logic l);
			res_t e;
			e.value_out = v;
			e.status = s;
			e.last = l;
			expected_results.push_back(e);
		endfunction

		function void note_command(cmd_t c);
			int unsigned spot;
			case (c.func)
				FN_PUSH_FRONT, FN_PUSH_BACK: begin
					if (occupied == DEPTH) begin
						add_result('0, ST_FULL, 1'b1);
					end else begin
						if (c.func == FN_PUSH_FRONT) begin
							head = (head + DEPTH - 1) % DEPTH;
							spot = head;
						end else begin
							spot = (head + occupied) % DEPTH;
						end
						slots[spot] = c.value_in;
						occupied++;
						add_result('0, ST_OK, 1'b1);
					end
				end
				FN_POP_FRONT, FN_POP_BACK: begin
					if (occupied == 0) begin
						add_result('0, ST_EMPTY, 1'b1);
					end else begin
						if (c.func == FN_POP_FRONT) begin
							spot = head;
							head = (head + 1) % DEPTH;
						end else begin
							spot = (head + occupied - 1) % DEPTH;
						end
						occupied--;
						add_result(slots[spot], ST_OK, 1'b1);
					end
				end
				FN_LIST: begin
					if (occupied == 0) begin
						add_result('0, ST_EMPTY, 1'b1);
					end else begin
						for (int unsigned i = 0; i < occupied; i++) begin
							add_result(slots[(head + i) % DEPTH], ST_OK, i + 1 == occupied);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_t r);
			res_t e;
			if (expected_results.size() == 0) begin
				$error("unexpected result: value_out %0d status %0d last %0d",
					r.value_out, r.status, r.last);
				mismatches++;
				return;
			end
			e = expected_results.pop_front();
			if (r.value_out !== e.value_out) begin
				$error("value_out: expected %0d, got %0d", e.value_out, r.value_out);
				mismatches++;
			end
			if (r.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, r.status);
				mismatches++;
			end
			if (r.last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, r.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	bit tx_calm;
	bit hold_request;
	int idle_cycles;
	deque_shadow shadow;

	bounded_deque_with_listing u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 15))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t make_cmd(func_t f, logic signed [DATA_W-1:0] v);
		cmd_t c;
		c.func = f;
		c.value_in = v;
		return c;
	endfunction

	function automatic func_t pick_push();
		return $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
	endfunction

	function automatic func_t pick_pop();
		return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
	endfunction

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 2) == 0) gap = idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		shadow.note_command(c);
	endtask

	// result sink with random backpressure and one long hold on request
	initial begin : result_sink
		int stall_left;
		int cycle_no;
		bit calm;
		stall_left = 0;
		cycle_no = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no % 128 == 0) calm = $urandom_range(0, 1);
			if (hold_request) begin
				hold_request = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
			end
		end
	end

	// result check and watchdog on transactions
	always @(posedge clk) begin
		if (res_valid && !res_stall) shadow.check_result(res);
		if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int r;
		shadow = new();
		idle_cycles = 0;
		tx_calm = 1'b1;
		hold_request = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, spare codes, single entries at both ends, extreme values
		send_cmd(make_cmd(FN_POP_FRONT, rand_value()));
		send_cmd(make_cmd(FN_POP_BACK, rand_value()));
		send_cmd(make_cmd(FN_LIST, rand_value()));
		for (int code = FN_SPARE_FIRST; code <= FN_SPARE_LAST; code++) begin
			send_cmd(make_cmd(func_t'(code), rand_value()));
		end
		send_cmd(make_cmd(FN_PUSH_FRONT, VAL_MIN));
		send_cmd(make_cmd(FN_POP_BACK, '0));
		send_cmd(make_cmd(FN_PUSH_BACK, VAL_MAX));
		send_cmd(make_cmd(FN_POP_FRONT, '0));
		tx_calm = 1'b0;
		send_cmd(make_cmd(FN_PUSH_FRONT, VAL_MIN));
		send_cmd(make_cmd(FN_PUSH_BACK, VAL_MAX));
		send_cmd(make_cmd(FN_PUSH_FRONT, '1));
		send_cmd(make_cmd(FN_PUSH_BACK, '0));
		send_cmd(make_cmd(FN_LIST, '0));
		send_cmd(make_cmd(FN_POP_FRONT, '0));
		send_cmd(make_cmd(FN_POP_BACK, '0));
		send_cmd(make_cmd(FN_LIST, '0));
		send_cmd(make_cmd(FN_POP_BACK, '0));
		send_cmd(make_cmd(FN_POP_BACK, '0));
		send_cmd(make_cmd(FN_POP_FRONT, '0));

		// fill to full under a long receiver hold, then overflow and list
		hold_request = 1'b1;
		tx_calm = 1'b1;
		while (shadow.occupied < DEPTH) begin
			if ($urandom_range(0, 19) == 0) begin
				send_cmd(make_cmd(pick_pop(), rand_value()));
			end else begin
				send_cmd(make_cmd(pick_push(), rand_value()));
			end
			if ($urandom_range(0, 15) == 0) tx_calm = ~tx_calm;
		end
		repeat (3) send_cmd(make_cmd(pick_push(), rand_value()));
		send_cmd(make_cmd(FN_LIST, rand_value()));

		// drain to empty with some pushes and short lists mixed in
		while (shadow.occupied > 0) begin
			r = $urandom_range(0, 19);
			if (r == 0 && shadow.occupied < 8) begin
				send_cmd(make_cmd(FN_LIST, rand_value()));
			end else if (r == 1) begin
				send_cmd(make_cmd(pick_push(), rand_value()));
			end else begin
				send_cmd(make_cmd(pick_pop(), rand_value()));
			end
			if ($urandom_range(0, 15) == 0) tx_calm = ~tx_calm;
		end
		send_cmd(make_cmd(pick_pop(), rand_value()));
		send_cmd(make_cmd(FN_LIST, rand_value()));

		// mixed traffic with spare codes
		for (int n = 0; n < 10; n++) begin
			r = $urandom_range(0, 19);
			if (n % 10 == 0) tx_calm = $urandom_range(0, 1);
			if (r == 0) begin
				send_cmd(make_cmd(func_t'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)),
					rand_value()));
			end else if (r == 1) begin
				send_cmd(make_cmd(FN_LIST, rand_value()));
			end else if (r < 11) begin
				send_cmd(make_cmd(pick_push(), rand_value()));
			end else begin
				send_cmd(make_cmd(pick_pop(), rand_value()));
			end
		end
		cmd_valid <= 1'b0;

		while (shadow.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/bdq_pkg.sv
design/bounded_deque_with_listing.sv
tb/testbench.sv
